/* hw/rtl/current_sense_calibrate_convert_defines.svh */
// Assertion macros for the current sense calibrate/convert block.
// Used by the port checker; the including scope must provide clk and rst_n.
`ifndef CURRENT_SENSE_CALIBRATE_CONVERT_DEFINES_SVH
`define CURRENT_SENSE_CALIBRATE_CONVERT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/csc_pkg.sv */
// Shared types and constants for the current sense calibrate/convert block.
// No dependencies; used by the interfaces, the top level and the checker.
package csc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int CUTOFF_W   = 12;
    localparam int VREF_W     = 16;
    localparam int FS_W       = 16;
    localparam int OFFS_W     = 16;
    localparam int GAIN_W     = 21;
    localparam int CUR_W      = 32;
    localparam int ZERO_W     = 12;
    localparam int SUM_W      = 17;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default ADC resolution
    localparam int ADC_BITS_DEF = 12;

    // Calibration limits
    localparam int CAL_LIMIT      = 32;
    localparam int CAL_DONE_COUNT = 31;

    // Millivolt to microvolt factor
    localparam int UV_PER_MV = 1000;

    // Register reset values
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 12'd4095;
    localparam logic [VREF_W-1:0]   VREF_RST   = 16'd3300;
    localparam logic [FS_W-1:0]     FS_RST     = 16'd4095;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_CUTOFF   = 3'd0,
        REG_VREF_MV        = 3'd1,
        REG_ADC_FULL_SCALE = 3'd2,
        REG_ADC_OFFSET_MV  = 3'd3,
        REG_SENSOR_GAIN_UV = 3'd4
    } csc_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } csc_state_t;

    // What the shared divider is working on
    typedef enum logic [1:0] {
        DIV_CAL,
        DIV_VOLT,
        DIV_CUR
    } csc_div_t;

endpackage

/* hw/rtl/csc_ifs.sv */
// Channel interfaces for the current sense calibrate/convert block.
// Depends on csc_pkg for field widths.
interface csc_sample_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [csc_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

interface csc_result_if;
    logic                          valid;
    logic                          ready;
    logic signed [csc_pkg::CUR_W-1:0] meas_current;
    logic                          calib_done;
    logic [csc_pkg::ZERO_W-1:0]    zero_level;

    modport source (output valid, meas_current, calib_done, zero_level, input ready);
    modport sink   (input valid, meas_current, calib_done, zero_level, output ready);
endinterface

interface csc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csc_pkg::CFG_IDX_W-1:0]   index;
    logic [csc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/current_sense_calibrate_convert.sv */
// Current sensor zero-offset calibration and current conversion, top level.
// Depends on csc_pkg and the channel interfaces in csc_ifs.sv.
//
//   channel    dir  payload                                transfer when
//   sample_ch  in   action, sample                         valid && ready
//   result_ch  out  meas_current, calib_done, zero_level   valid && ready
//   cfg        in   index, data                            valid && ready
//
// One item at a time. Calibration runs the 17-step divider only when the
// offset is recomputed. Measurement runs the 12-step bit-serial multiply and
// the shared restoring divider (28 + 40 steps). Zero scale or gain skips both.
// A waiting result does not block the next item; a finished item stalls in
// ST_OUT until the output register is free.
// rst_n clears control, configuration and calibration state; the datapath
// shift registers are loaded on each transfer. cfg is always ready.
module current_sense_calibrate_convert #(
    parameter int ADC_BITS = csc_pkg::ADC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    csc_sample_if.sink   sample_ch,
    csc_result_if.source result_ch,
    csc_cfg_if.sink      cfg
);
    import csc_pkg::*;

    // Sample bits actually used
    localparam int RAW_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + VREF_W;
    localparam int DVD_W  = 40;
    localparam int DVS_W  = GAIN_W;
    localparam int DIFF_W = PROD_W + 2;
    localparam int MAG_W  = PROD_W + 1;
    localparam int CNT_W  = 6;

    // Configuration registers
    logic [CUTOFF_W-1:0]     cutoff_reg;
    logic [VREF_W-1:0]       vref_reg;
    logic [FS_W-1:0]         fs_reg;
    logic signed [OFFS_W-1:0] offs_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    // Calibration state
    logic [SUM_W-1:0]   calib_sum_reg,   calib_sum_next;
    logic [COUNT_W-1:0] calib_count_reg, calib_count_next;
    logic [ZERO_W-1:0]  zero_offset_reg;

    // Sequencer
    csc_state_t state_reg, state_next;
    csc_div_t   kind_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic       meas_reg;

    // Datapath shift registers
    logic [SAMPLE_W-1:0] mplr_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    dvs_reg;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic                neg_reg;

    // Output register
    logic                    out_valid_reg;
    logic signed [CUR_W-1:0] cur_reg;
    logic                    done_reg;
    logic [ZERO_W-1:0]       zero_reg;

    logic in_acc, cfg_acc, out_load, cal_take, cal_div;
    logic [SAMPLE_W-1:0] sample_m, raw;
    logic [DVS_W+1:0]    trial;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]    mag;
    logic [DVD_W-1:0]    num;
    logic [DVS_W-1:0]    gain_mag;
    logic signed [CUR_W-1:0] sat;

    assign in_acc  = sample_ch.valid && sample_ch.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result_ch.ready);

    // Sample masked to the ADC resolution, offset removed with clamp at zero
    always_comb
    begin
        sample_m = '0;
        sample_m[RAW_W-1:0] = sample_ch.sample[RAW_W-1:0];
        raw = (sample_m > zero_offset_reg) ? (sample_m - zero_offset_reg) : '0;
    end

    // Calibration accumulate
    assign cal_take = (calib_count_reg < COUNT_W'(CAL_LIMIT))
                      && (sample_m <= cutoff_reg);
    always_comb
    begin
        calib_sum_next   = calib_sum_reg;
        calib_count_next = calib_count_reg;
        if (cal_take)
        begin
            calib_sum_next   = calib_sum_reg + SUM_W'(sample_m);
            calib_count_next = calib_count_reg + COUNT_W'(1);
        end
    end
    assign cal_div = calib_count_next >= COUNT_W'(CAL_DONE_COUNT);

    // Multiplier step, MSB of the multiplier first
    assign prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                     + (mplr_reg[SAMPLE_W-1] ? PROD_W'(vref_reg) : '0);

    // Restoring divider step
    always_comb
    begin
        trial    = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b00, dvs_reg};
        rem_next = trial[DVS_W+1] ? {rem_reg[DVS_W-2:0], dvd_reg[DVD_W-1]}
                                  : trial[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ~trial[DVS_W+1]};
    end

    // Offset removal, scale to microvolts, operand signs
    always_comb
    begin
        diff = $signed({2'b00, dvd_reg[PROD_W-1:0]})
             - $signed({{(DIFF_W-OFFS_W){offs_reg[OFFS_W-1]}}, offs_reg});
        mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        num  = DVD_W'(mag) * DVD_W'(UV_PER_MV);
        gain_mag = gain_reg[GAIN_W-1] ? DVS_W'(-gain_reg) : DVS_W'(gain_reg);
    end

    // Sign and saturation of the final quotient
    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > DVD_W'(64'h8000_0000))
                sat = {1'b1, {(CUR_W-1){1'b0}}};
            else
                sat = -$signed(dvd_reg[CUR_W-1:0]);
        end
        else
        begin
            if (dvd_reg > DVD_W'(64'h7FFF_FFFF))
                sat = {1'b0, {(CUR_W-1){1'b1}}};
            else
                sat = $signed(dvd_reg[CUR_W-1:0]);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!sample_ch.action)
                        state_next = cal_div ? ST_DIV : ST_OUT;
                    else if (fs_reg == '0 || gain_reg == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = (kind_reg == DIV_VOLT) ? ST_SCALE : ST_OUT;
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        sample_ch.ready        = (state_reg == ST_IDLE);
        cfg.ready              = 1'b1;
        result_ch.valid        = out_valid_reg;
        result_ch.meas_current = cur_reg;
        result_ch.calib_done   = done_reg;
        result_ch.zero_level   = zero_reg;
    end

    // Control, configuration and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= DIV_CAL;
            cnt_reg         <= '0;
            meas_reg        <= 1'b0;
            cutoff_reg      <= CUTOFF_RST;
            vref_reg        <= VREF_RST;
            fs_reg          <= FS_RST;
            offs_reg        <= '0;
            gain_reg        <= '0;
            calib_sum_reg   <= '0;
            calib_count_reg <= '0;
            zero_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
            cur_reg         <= '0;
            done_reg        <= 1'b0;
            zero_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_CALIB_CUTOFF:   cutoff_reg <= cfg.data[CUTOFF_W-1:0];
                    REG_VREF_MV:        vref_reg   <= cfg.data[VREF_W-1:0];
                    REG_ADC_FULL_SCALE: fs_reg     <= cfg.data[FS_W-1:0];
                    REG_ADC_OFFSET_MV:  offs_reg   <= $signed(cfg.data[OFFS_W-1:0]);
                    REG_SENSOR_GAIN_UV: gain_reg   <= $signed(cfg.data[GAIN_W-1:0]);
                    default:            ;
                endcase
            end

            // Step counter and divider job
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        meas_reg <= sample_ch.action;
                        if (!sample_ch.action)
                        begin
                            calib_sum_reg   <= calib_sum_next;
                            calib_count_reg <= calib_count_next;
                            kind_reg        <= DIV_CAL;
                            cnt_reg         <= CNT_W'(SUM_W);
                        end
                        else
                        begin
                            cnt_reg <= CNT_W'(SAMPLE_W);
                        end
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == CNT_W'(1))
                    begin
                        kind_reg <= DIV_VOLT;
                        cnt_reg  <= CNT_W'(PROD_W);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1) && kind_reg == DIV_CAL)
                        zero_offset_reg <= dvd_next[ZERO_W-1:0];
                end
                ST_SCALE:
                begin
                    kind_reg <= DIV_CUR;
                    cnt_reg  <= CNT_W'(DVD_W);
                end
                default:
                begin
                end
            endcase

            // Output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= meas_reg ? sat : '0;
                done_reg      <= calib_count_reg >= COUNT_W'(CAL_DONE_COUNT);
                zero_reg      <= zero_offset_reg;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Multiplier and divider shift registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mplr_reg <= raw;
                    prod_reg <= '0;
                    rem_reg  <= '0;
                    neg_reg  <= 1'b0;
                    if (!sample_ch.action)
                    begin
                        dvd_reg <= {calib_sum_next, {(DVD_W-SUM_W){1'b0}}};
                        dvs_reg <= DVS_W'(calib_count_next);
                    end
                    else
                    begin
                        dvd_reg <= '0;
                        dvs_reg <= DVS_W'(fs_reg);
                    end
                end
            end
            ST_MUL:
            begin
                prod_reg <= prod_next;
                mplr_reg <= {mplr_reg[SAMPLE_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(1))
                    dvd_reg <= {prod_next, {(DVD_W-PROD_W){1'b0}}};
            end
            ST_DIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
            ST_SCALE:
            begin
                dvd_reg <= num;
                dvs_reg <= gain_mag;
                rem_reg <= '0;
                neg_reg <= diff[DIFF_W-1] ^ gain_reg[GAIN_W-1];
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/csc_checker.sv */
// Port checker for current_sense_calibrate_convert, bound to the top level.
// Depends on csc_pkg and the assertion macros header.
`include "current_sense_calibrate_convert_defines.svh"

module csc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [csc_pkg::CUR_W-1:0]    meas_current,
    input logic                                calib_done,
    input logic [csc_pkg::ZERO_W-1:0]          zero_level
);
    import csc_pkg::*;

    // A stalled result holds its payload
    `CSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(meas_current) && $stable(calib_done) && $stable(zero_level), "result changed while stalled")

    // Only one item in flight
    `CSC_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

    // Calibration never comes undone
    `CSC_ASSERT_IMP(a_done_sticky, 1'b1, !$fell(calib_done), "calib_done fell")

    // No zero offset before calibration completes
    `CSC_ASSERT_IMP(a_zero_before_done, out_valid && !calib_done, zero_level == '0, "offset set before done")

endmodule

bind current_sense_calibrate_convert csc_checker u_csc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .meas_current (result_ch.meas_current),
    .calib_done   (result_ch.calib_done),
    .zero_level   (result_ch.zero_level)
);

/* test/current_sense_calibrate_convert_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for current_sense_calibrate_convert: directed corner cases,
// then calibration fill and randomised conversion phases, with a built-in predictor.
// Depends on csc_pkg, the channel interfaces in csc_ifs.sv and the top-level RTL.
module current_sense_calibrate_convert_tb;
    import csc_pkg::*;

    localparam int ADC_BITS    = ADC_BITS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 90;
    localparam int END_SETTLE  = 100;
    localparam int CFG_SETTLE  = 5;

    // Item kinds on the sample channel
    localparam logic ACT_CALIBRATE = 1'b0;
    localparam logic ACT_MEASURE   = 1'b1;

    localparam longint CUR_MAX = (longint'(1) <<< (CUR_W - 1)) - 1;
    localparam longint CUR_MIN = -(longint'(1) <<< (CUR_W - 1));

    typedef struct {
        logic signed [CUR_W-1:0] meas_current;
        logic                    calib_done;
        logic [ZERO_W-1:0]       zero_level;
    } reading_t;

    logic clk;
    logic rst_n;

    csc_sample_if sample_ch ();
    csc_result_if result_ch ();
    csc_cfg_if    cfg ();

    current_sense_calibrate_convert #(
        .ADC_BITS (ADC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg       (cfg)
    );

    // Predictor copy of the registers and calibration state
    logic [CUTOFF_W-1:0]      p_cutoff;
    logic [VREF_W-1:0]        p_vref;
    logic [FS_W-1:0]          p_full_scale;
    logic signed [OFFS_W-1:0] p_offset;
    logic signed [GAIN_W-1:0] p_gain;
    logic [SUM_W-1:0]         p_sum;
    logic [COUNT_W-1:0]       p_count;
    logic [ZERO_W-1:0]        p_zero;

    reading_t expected_readings[$];
    int       mismatches;
    bit       steady_flow;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_predictor();
        p_cutoff     = CUTOFF_RST;
        p_vref       = VREF_RST;
        p_full_scale = FS_RST;
        p_offset     = '0;
        p_gain       = '0;
        p_sum        = '0;
        p_count      = '0;
        p_zero       = '0;
    endfunction

    // Offset removal, scaling to mV, converter offset, gain division, saturation
    function automatic logic signed [CUR_W-1:0] convert_current(
        input logic [SAMPLE_W-1:0] code
    );
        logic [SAMPLE_W-1:0] above_zero;
        longint volt_mv;
        longint scaled;
        longint amps;
        above_zero = (code > p_zero) ? code - p_zero : '0;
        if (p_full_scale == 0 || p_gain == 0)
            return '0;
        volt_mv = (longint'(above_zero) * longint'(p_vref)) / longint'(p_full_scale);
        scaled  = (volt_mv - longint'(p_offset)) * UV_PER_MV;
        amps    = scaled / longint'(p_gain);
        if (amps > CUR_MAX)
            amps = CUR_MAX;
        if (amps < CUR_MIN)
            amps = CUR_MIN;
        return amps[CUR_W-1:0];
    endfunction

    // Update calibration state for one accepted item and queue its reading
    function automatic void predict_reading(input logic op,
                                            input logic [SAMPLE_W-1:0] raw_sample);
        logic [SAMPLE_W-1:0] code;
        reading_t            r;
        code = raw_sample & SAMPLE_W'((1 << ADC_BITS) - 1);
        r.meas_current = '0;
        if (op == ACT_CALIBRATE)
        begin
            if (p_count < CAL_LIMIT && code <= p_cutoff)
            begin
                p_sum   = p_sum + SUM_W'(code);
                p_count = p_count + COUNT_W'(1);
            end
            if (p_count >= CAL_DONE_COUNT)
                p_zero = ZERO_W'(p_sum / SUM_W'(p_count));
        end
        else
        begin
            r.meas_current = convert_current(code);
        end
        r.calib_done = (p_count >= CAL_DONE_COUNT);
        r.zero_level = p_zero;
        expected_readings.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // One sample transfer; valid stays high when the next item follows at once
    task automatic send_sample(input logic op, input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.action <= op;
        sample_ch.sample <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predict_reading(op, value);
    endtask

    // Stop sending and let every outstanding reading arrive
    task automatic wait_for_readings(input int settle);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One register transfer; the caller lowers valid after the last one
    task automatic write_reg(input csc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_CALIB_CUTOFF:   p_cutoff     = value[CUTOFF_W-1:0];
            REG_VREF_MV:        p_vref       = value[VREF_W-1:0];
            REG_ADC_FULL_SCALE: p_full_scale = value[FS_W-1:0];
            REG_ADC_OFFSET_MV:  p_offset     = value[OFFS_W-1:0];
            REG_SENSOR_GAIN_UV: p_gain       = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block has gone idle
    task automatic set_config(input logic [CUTOFF_W-1:0]      cutoff,
                              input logic [VREF_W-1:0]        vref,
                              input logic [FS_W-1:0]          full_scale,
                              input logic signed [OFFS_W-1:0] offset,
                              input logic signed [GAIN_W-1:0] gain);
        wait_for_readings(CFG_SETTLE);
        write_reg(REG_CALIB_CUTOFF, CFG_DATA_W'(cutoff));
        write_reg(REG_VREF_MV, CFG_DATA_W'(vref));
        write_reg(REG_ADC_FULL_SCALE, CFG_DATA_W'(full_scale));
        write_reg(REG_ADC_OFFSET_MV, {{(CFG_DATA_W - OFFS_W){offset[OFFS_W-1]}}, offset});
        write_reg(REG_SENSOR_GAIN_UV, {{(CFG_DATA_W - GAIN_W){gain[GAIN_W-1]}}, gain});
        cfg.valid <= 1'b0;
    endtask

    // Reset values: gain of zero forces every current to zero
    task automatic test_power_on();
        send_sample(ACT_MEASURE, 12'd0);
        send_sample(ACT_MEASURE, 12'd4095);
    endtask

    // Zero full scale or zero gain, then a normal conversion
    task automatic test_zero_divisors();
        set_config(12'd4095, 16'd3300, 16'd0, 16'sd0, 21'sd40000);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd3300, 16'd4095, 16'sd0, 21'sd0);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd3300, 16'd4095, 16'sd0, 21'sd40000);
        send_sample(ACT_MEASURE, 12'd2048);
    endtask

    // Register extremes, both saturation limits and negative numerators
    task automatic test_conversion_extremes();
        set_config(12'd4095, 16'd65535, 16'd1, -16'sd32768, 21'sd1);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd65535, 16'd1, -16'sd32768, -21'sd1);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd65535, 16'd1, -16'sd32768, 21'sd1000000);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd65535, 16'd1, 16'sd32767, -21'sd1000000);
        send_sample(ACT_MEASURE, 12'd0);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd0, 16'd65535, 16'sd32767, 21'sd1);
        send_sample(ACT_MEASURE, 12'd4095);
        set_config(12'd4095, 16'd65535, 16'd65535, 16'sd0, -21'sd1);
        send_sample(ACT_MEASURE, 12'd4095);
    endtask

    // Samples above the cutoff are dropped, samples at it are taken
    task automatic test_calibration_cutoff();
        set_config(12'd4095, 16'd3300, 16'd4095, 16'sd0, 21'sd40000);
        send_sample(ACT_CALIBRATE, 12'd4095);
        send_sample(ACT_CALIBRATE, 12'd0);
        set_config(12'd2000, 16'd3300, 16'd4095, 16'sd0, 21'sd40000);
        send_sample(ACT_CALIBRATE, 12'd2001);
        send_sample(ACT_CALIBRATE, 12'd2000);
        send_sample(ACT_MEASURE, 12'd1000);
        set_config(12'd0, 16'd3300, 16'd4095, 16'sd0, 21'sd40000);
        send_sample(ACT_CALIBRATE, 12'd1);
        send_sample(ACT_CALIBRATE, 12'd0);
    endtask

    // Fill the calibration sum past done, then overfill it
    task automatic test_calibration_fill();
        logic [CUTOFF_W-1:0] cutoff;
        cutoff = CUTOFF_W'($urandom_range(1024, 4095));
        set_config(cutoff, 16'd3300, 16'd4095, 16'sd0, 21'sd40000);
        while (p_count < CAL_LIMIT)
        begin
            if ($urandom_range(0, 99) < 20)
                send_sample(ACT_MEASURE, SAMPLE_W'($urandom_range(0, 4095)));
            else if ($urandom_range(0, 99) < 15 && cutoff != 12'd4095)
                send_sample(ACT_CALIBRATE, SAMPLE_W'($urandom_range(int'(cutoff) + 1, 4095)));
            else
                send_sample(ACT_CALIBRATE, SAMPLE_W'($urandom_range(0, int'(cutoff))));
        end
        repeat (4)
            send_sample(ACT_CALIBRATE, SAMPLE_W'($urandom_range(0, int'(cutoff))));
    endtask

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        int roll;
        int mag;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return GAIN_W'(1000000);
        if (roll < 10)
            return GAIN_W'(-1000000);
        if (roll < 13)
            return GAIN_W'(1);
        if (roll < 16)
            return GAIN_W'(-1);
        if (roll < 20)
            return '0;
        mag = $urandom_range(1000, 200000);
        return GAIN_W'(($urandom_range(0, 1) != 0) ? -mag : mag);
    endfunction

    // Random register settings per phase, mostly measurements with some noise
    task automatic test_random_phases();
        logic [CUTOFF_W-1:0]      cutoff;
        logic [VREF_W-1:0]        vref;
        logic [FS_W-1:0]          full_scale;
        logic signed [OFFS_W-1:0] offset;
        int                       roll;
        int                       taken;
        int                       code;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            roll   = $urandom_range(0, 2);
            cutoff = (roll == 0) ? 12'd0 : (roll == 1) ? 12'd4095
                                 : CUTOFF_W'($urandom_range(0, 4095));
            roll   = $urandom_range(0, 99);
            vref   = (roll < 10) ? 16'd0 : (roll < 20) ? 16'd65535
                                 : VREF_W'($urandom_range(1000, 5000));
            roll   = $urandom_range(0, 99);
            full_scale = (roll < 5) ? 16'd0 : (roll < 10) ? 16'd1
                       : (roll < 15) ? 16'd65535 : FS_W'($urandom_range(256, 8191));
            roll   = $urandom_range(0, 99);
            offset = (roll < 10) ? -16'sd32768 : (roll < 20) ? 16'sd32767
                   : OFFS_W'(int'($urandom_range(0, 400)) - 200);
            set_config(cutoff, vref, full_scale, offset, pick_gain());
            steady_flow = (phase % 4 == 3);
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_sample(ACT_CALIBRATE, SAMPLE_W'($urandom_range(0, 4095)));
                end
                else
                begin
                    // Some samples straddle the zero level to hit the clamp
                    if ($urandom_range(0, 9) < 3)
                    begin
                        code = int'(p_zero) + int'($urandom_range(0, 16)) - 8;
                        if (code < 0)
                            code = 0;
                        if (code > 4095)
                            code = 4095;
                    end
                    else
                    begin
                        code = $urandom_range(0, 4095);
                    end
                    send_sample(ACT_MEASURE, SAMPLE_W'(code));
                    taken++;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // Result channel ready with random stalls
    initial
    begin : result_ready_driver
        int hold;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expected reading
    initial
    begin : result_checker
        reading_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result meas_current=%0d",
                                              result_ch.meas_current));
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (result_ch.meas_current !== want.meas_current)
                        report_mismatch($sformatf("meas_current got %0d want %0d",
                                                  result_ch.meas_current,
                                                  want.meas_current));
                    if (result_ch.calib_done !== want.calib_done)
                        report_mismatch($sformatf("calib_done got %b want %b",
                                                  result_ch.calib_done, want.calib_done));
                    if (result_ch.zero_level !== want.zero_level)
                        report_mismatch($sformatf("zero_level got %0d want %0d",
                                                  result_ch.zero_level, want.zero_level));
                end
            end
        end
    end

    // Ends the run if no transfer happens for too long
    initial
    begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg.valid === 1'b1 && cfg.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("current_sense_calibrate_convert_tb: FAIL");
        $finish;
    end

    // Test sequence
    initial
    begin
        mismatches       = 0;
        steady_flow      = 1'b0;
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.action <= ACT_CALIBRATE;
        sample_ch.sample <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_CALIB_CUTOFF;
        cfg.data         <= '0;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_zero_divisors();
        test_conversion_extremes();
        test_calibration_cutoff();
        test_calibration_fill();
        test_random_phases();

        wait_for_readings(END_SETTLE);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("current_sense_calibrate_convert_tb: PASS");
        else
            $display("current_sense_calibrate_convert_tb: FAIL");
        $finish;
    end

endmodule
